FILE: rtl/msbbs_pkg.sv
// Shared constants, types and command codes of the MSB-first bit stream buffer.
package msbbs_pkg;

    localparam int BUFFER_BYTES   = 256;
    localparam int MAX_FIELD_BITS = 32;
    localparam int FIELD_W        = 32;
    localparam int ADDR_W         = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int POS_W          = $clog2(8 * BUFFER_BYTES + MAX_FIELD_BITS + 1);
    localparam int NB_W           = $clog2(MAX_FIELD_BITS + 1);

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [ADDR_W:0]    t_cnt;
    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [POS_W:0]     t_posx;
    typedef logic [NB_W-1:0]    t_nbits;
    typedef logic [3:0]         t_take;
    typedef logic [7:0]         t_byte;
    typedef logic [FIELD_W-1:0] t_field;

    typedef enum logic [2:0] {
        CMD_CREATE     = 3'd0,
        CMD_DEFINE     = 3'd1,
        CMD_WRITE_BYTE = 3'd2,
        CMD_READ_BYTE  = 3'd3,
        CMD_PUT_BITS   = 3'd4,
        CMD_PAD        = 3'd5,
        CMD_COMMIT     = 3'd6,
        CMD_GET_BITS   = 3'd7
    } t_cmd;

    localparam t_byte START_MARK = 8'h80;
    localparam t_byte BYTE_ONES  = 8'hFF;

endpackage

FILE: rtl/msb_first_bit_stream_buffer.sv
// Top level of the MSB-first bit stream buffer: byte store, pointers and command sequencer.
// One word is handled at a time. Define, commit, refusals, zero counts, empty creates and aligned
// pads go straight to the result state; write_byte passes a write state, read_byte and pad a request
// and a response state, put_bits an align state and a request/response pair per byte touched, get_bits
// such a pair per byte, create a clear state per byte of the clamped size. A new word is taken after
// the result registers; a waiting result holds the next one back. Sync active-low reset clears state.
module msb_first_bit_stream_buffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_field_value,
    input  logic [5:0]  i_bit_count,
    input  logic [8:0]  i_size_bytes,
    input  logic        i_start_bit,
    input  logic [7:0]  i_byte_address,
    input  logic [7:0]  i_byte_data,
    input  logic [31:0] i_samples_added,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_ok,
    output logic [31:0] o_data_value,
    output logic [8:0]  o_byte_length,
    output logic [31:0] o_sample_total
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_WRITE,
        S_READ_RQ,
        S_READ_RSP,
        S_PUT_ALIGN,
        S_PUT_RQ,
        S_PUT_RSP,
        S_GET_RQ,
        S_GET_RSP,
        S_PAD_RQ,
        S_PAD_RSP,
        S_DONE
    } t_state;

    t_state                r_state;
    msbbs_pkg::t_pos       r_size_bits;
    msbbs_pkg::t_pos       r_bitpos;
    msbbs_pkg::t_pos       r_commit;
    logic [31:0]           r_samples;
    logic                  r_ok;
    msbbs_pkg::t_field     r_data;
    msbbs_pkg::t_field     r_sh;
    msbbs_pkg::t_nbits     r_rem;
    msbbs_pkg::t_addr      r_addr;
    msbbs_pkg::t_byte      r_bdata;
    logic                  r_start;
    msbbs_pkg::t_cnt       r_size;
    msbbs_pkg::t_cnt       r_idx;

    logic                  w_accept;
    msbbs_pkg::t_cmd       w_cmd;
    msbbs_pkg::t_cnt       w_size;
    msbbs_pkg::t_nbits     w_count;
    logic                  w_addr_ok;
    logic                  w_fits;
    logic                  w_behind;
    msbbs_pkg::t_pos       w_avail;
    logic                  w_short;
    logic [2:0]            w_ofs;
    msbbs_pkg::t_take      w_room;
    msbbs_pkg::t_take      w_take;
    logic [5:0]            w_align;
    msbbs_pkg::t_byte      w_rd;
    msbbs_pkg::t_byte      w_get_bits;
    msbbs_pkg::t_posx      w_round;
    logic                  w_we;
    msbbs_pkg::t_addr      w_ram_addr;
    msbbs_pkg::t_byte      w_wdata;
    logic                  w_clear_last;

    assign o_ready   = (r_state == S_IDLE);
    assign w_accept  = i_valid && o_ready;
    assign w_cmd     = msbbs_pkg::t_cmd'(i_command);

    assign w_size    = (int'(i_size_bytes) > msbbs_pkg::BUFFER_BYTES)
                     ? msbbs_pkg::t_cnt'(msbbs_pkg::BUFFER_BYTES)
                     : msbbs_pkg::t_cnt'(i_size_bytes);
    assign w_count   = (i_bit_count > 6'(msbbs_pkg::MAX_FIELD_BITS))
                     ? msbbs_pkg::t_nbits'(msbbs_pkg::MAX_FIELD_BITS)
                     : msbbs_pkg::t_nbits'(i_bit_count);
    assign w_addr_ok = int'(i_byte_address) < msbbs_pkg::BUFFER_BYTES;

    assign w_fits    = (msbbs_pkg::t_posx'(r_bitpos) + msbbs_pkg::t_posx'(w_count))
                       <= msbbs_pkg::t_posx'(r_size_bits);
    assign w_behind  = r_bitpos < r_commit;
    assign w_avail   = w_behind ? (r_commit - r_bitpos) : '0;
    assign w_short   = msbbs_pkg::t_posx'(w_count) > msbbs_pkg::t_posx'(w_avail);

    assign w_ofs     = r_bitpos[2:0];
    assign w_room    = 4'd8 - {1'b0, w_ofs};
    assign w_take    = (r_rem < msbbs_pkg::t_nbits'(w_room))
                     ? msbbs_pkg::t_take'(r_rem) : w_room;
    assign w_align   = 6'(msbbs_pkg::FIELD_W) - 6'(r_rem);

    assign w_get_bits = msbbs_pkg::t_byte'(w_rd << w_ofs) >> (4'd8 - w_take);
    assign w_round    = msbbs_pkg::t_posx'(r_commit) + msbbs_pkg::t_posx'(3'd7);
    assign w_clear_last = (msbbs_pkg::t_cnt'(r_idx + 1'b1) == r_size);

    always_comb begin
        w_we       = 1'b0;
        w_wdata    = '0;
        w_ram_addr = msbbs_pkg::t_addr'(r_bitpos >> 3);
        unique case (r_state)
            S_CLEAR: begin
                w_we       = 1'b1;
                w_ram_addr = msbbs_pkg::t_addr'(r_idx);
                w_wdata    = (r_idx == '0 && r_start) ? msbbs_pkg::START_MARK : '0;
            end
            S_WRITE: begin
                w_we       = 1'b1;
                w_ram_addr = r_addr;
                w_wdata    = r_bdata;
            end
            S_READ_RQ: begin
                w_ram_addr = r_addr;
            end
            S_PUT_RSP: begin
                w_we    = 1'b1;
                w_wdata = w_rd | (r_sh[msbbs_pkg::FIELD_W-1 -: 8] >> w_ofs);
            end
            S_PAD_RQ: begin
                w_ram_addr = msbbs_pkg::t_addr'(r_commit >> 3);
            end
            S_PAD_RSP: begin
                w_we       = 1'b1;
                w_ram_addr = msbbs_pkg::t_addr'(r_commit >> 3);
                w_wdata    = w_rd | (msbbs_pkg::BYTE_ONES >> r_commit[2:0]);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    msbbs_ram #(
        .WIDTH (8),
        .DEPTH (msbbs_pkg::BUFFER_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_ram_addr),
        .i_wdata (w_wdata),
        .i_raddr (w_ram_addr),
        .o_rdata (w_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_valid     <= 1'b0;
            r_size_bits <= '0;
            r_bitpos    <= '0;
            r_commit    <= '0;
            r_samples   <= '0;
        end else begin
            if (o_valid && i_ready && r_state != S_DONE) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_ok    <= 1'b1;
                        r_data  <= '0;
                        r_rem   <= w_count;
                        r_sh    <= i_field_value;
                        r_addr  <= msbbs_pkg::t_addr'(i_byte_address);
                        r_bdata <= i_byte_data;
                        r_start <= i_start_bit;
                        r_size  <= w_size;
                        r_idx   <= '0;
                        unique case (w_cmd)
                            msbbs_pkg::CMD_CREATE: begin
                                r_size_bits <= msbbs_pkg::t_pos'({w_size, 3'b000});
                                r_samples   <= '0;
                                if (i_start_bit && w_size != '0) begin
                                    r_bitpos <= msbbs_pkg::t_pos'(1);
                                    r_commit <= msbbs_pkg::t_pos'(1);
                                end else begin
                                    r_bitpos <= '0;
                                    r_commit <= '0;
                                end
                                r_state <= (w_size != '0) ? S_CLEAR : S_DONE;
                            end
                            msbbs_pkg::CMD_DEFINE: begin
                                r_size_bits <= msbbs_pkg::t_pos'({w_size, 3'b000});
                                r_bitpos    <= '0;
                                r_commit    <= msbbs_pkg::t_pos'({w_size, 3'b000});
                                r_samples   <= '0;
                                r_state     <= S_DONE;
                            end
                            msbbs_pkg::CMD_WRITE_BYTE: begin
                                r_state <= w_addr_ok ? S_WRITE : S_DONE;
                            end
                            msbbs_pkg::CMD_READ_BYTE: begin
                                r_state <= w_addr_ok ? S_READ_RQ : S_DONE;
                            end
                            msbbs_pkg::CMD_PUT_BITS: begin
                                if (!w_fits) begin
                                    r_ok    <= 1'b0;
                                    r_state <= S_DONE;
                                end else if (w_count == '0) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_PUT_ALIGN;
                                end
                            end
                            msbbs_pkg::CMD_PAD: begin
                                r_state <= (r_commit[2:0] != 3'd0) ? S_PAD_RQ : S_DONE;
                            end
                            msbbs_pkg::CMD_COMMIT: begin
                                r_commit  <= r_bitpos;
                                r_samples <= r_samples + i_samples_added;
                                r_state   <= S_DONE;
                            end
                            msbbs_pkg::CMD_GET_BITS: begin
                                if (w_short) begin
                                    r_ok <= 1'b0;
                                    if (w_behind) begin
                                        r_bitpos <= r_commit;
                                    end
                                    r_state <= S_DONE;
                                end else if (w_count == '0) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_GET_RQ;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    r_idx <= msbbs_pkg::t_cnt'(r_idx + 1'b1);
                    if (w_clear_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_WRITE: begin
                    r_state <= S_DONE;
                end
                S_READ_RQ: begin
                    r_state <= S_READ_RSP;
                end
                S_READ_RSP: begin
                    r_data  <= msbbs_pkg::t_field'(w_rd);
                    r_state <= S_DONE;
                end
                S_PUT_ALIGN: begin
                    r_sh    <= r_sh << w_align;
                    r_state <= S_PUT_RQ;
                end
                S_PUT_RQ: begin
                    r_state <= S_PUT_RSP;
                end
                S_PUT_RSP: begin
                    r_sh     <= r_sh << w_take;
                    r_bitpos <= r_bitpos + msbbs_pkg::t_pos'(w_take);
                    r_rem    <= r_rem - msbbs_pkg::t_nbits'(w_take);
                    r_state  <= (r_rem == msbbs_pkg::t_nbits'(w_take)) ? S_DONE : S_PUT_RQ;
                end
                S_GET_RQ: begin
                    r_state <= S_GET_RSP;
                end
                S_GET_RSP: begin
                    r_data   <= (r_data << w_take) | msbbs_pkg::t_field'(w_get_bits);
                    r_bitpos <= r_bitpos + msbbs_pkg::t_pos'(w_take);
                    r_rem    <= r_rem - msbbs_pkg::t_nbits'(w_take);
                    r_state  <= (r_rem == msbbs_pkg::t_nbits'(w_take)) ? S_DONE : S_GET_RQ;
                end
                S_PAD_RQ: begin
                    r_state <= S_PAD_RSP;
                end
                S_PAD_RSP: begin
                    r_commit <= {r_commit[msbbs_pkg::POS_W-1:3] + 1'b1, 3'b000};
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!o_valid || i_ready) begin
                        o_valid        <= 1'b1;
                        o_ok           <= r_ok;
                        o_data_value   <= r_data;
                        o_byte_length  <= 9'(w_round >> 3);
                        o_sample_total <= r_samples;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/msbbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module msbbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/msbbs_chk.sv
// Port-level checker for the MSB-first bit stream buffer, bound to the top level.
module msbbs_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_ok,
    input logic [31:0] o_data_value,
    input logic [8:0]  o_byte_length
);

    // A stalled result word holds its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_ok) && $stable(o_data_value)
                                   && $stable(o_byte_length)))
        else $error("result word changed while stalled");

    // Only one word is in progress at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second word accepted while one is in progress");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_data_value == 32'd0))
        else $error("failed command returned data");

    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(o_byte_length) <= msbbs_pkg::BUFFER_BYTES))
        else $error("committed length beyond the store");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("handshake not idle after reset");

endmodule

bind msb_first_bit_stream_buffer msbbs_chk u_msbbs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_ok          (o_ok),
    .o_data_value  (o_data_value),
    .o_byte_length (o_byte_length)
);
